// ===== hdl/earb_pkg.sv =====
// ============================================================================
// earb_pkg: shared types and constants for the elastic audio ring buffer
// Holds the default sizes, opcode values, run mode encoding and the record
// that travels with a read word from the control stage to the output stage.
// ============================================================================
package earb_pkg;

    // Default sizes of the ring.
    localparam int CHUNK_SIZE_DEF        = 64;
    localparam int MAX_CHUNKS_DEF        = 8;
    localparam int MAX_FRAME_SAMPLES_DEF = 128;

    // Fixed widths of the payload fields.
    localparam int SAMPLE_W = 16;
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int CFG_W    = 4;
    localparam int CNT_W    = 32;

    // Ring length in chunks after reset.
    localparam int RESET_CHUNKS = 8;

    // Opcodes of an input word.
    localparam logic [OP_W-1:0] OP_WRITE      = 3'd0;
    localparam logic [OP_W-1:0] OP_READ       = 3'd1;
    localparam logic [OP_W-1:0] OP_RESTART    = 3'd2;
    localparam logic [OP_W-1:0] OP_CONNECT    = 3'd3;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd4;

    // Run mode of the buffer.
    typedef enum logic [1:0] {
        MODE_UNDEFINED  = 2'd0,
        MODE_WILL_START = 2'd1,
        MODE_RUNNING    = 2'd2
    } mode_t;

    // What the output stage needs to know about one read word.
    typedef struct packed {
        logic use_mem;     // sample comes from the store
        logic clear_held;  // block start: held sample restarts at zero
        logic underrun;    // this block's distance was below quarter ring
        logic overrun;     // overrun flag at the time of the read
    } rd_info_t;

endpackage

// ===== hdl/earb_store.sv =====
// ============================================================================
// earb_store: sample memory with a clearing pass after reset
// One write port and one read port with registered read data. After reset
// the memory is swept to zero, one entry per cycle, while busy is high.
// ============================================================================
module earb_store
    import earb_pkg::*;
#(
    parameter int DEPTH = MAX_CHUNKS_DEF * CHUNK_SIZE_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [SAMPLE_W-1:0] wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output logic [SAMPLE_W-1:0] rd_data,
    output logic                busy
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                busy_reg;
    logic                busy_next;
    logic [AW-1:0]       clr_idx_reg;
    logic [AW-1:0]       clr_idx_next;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [SAMPLE_W-1:0] mem_wdata;

    // Clearing pass: walk every entry once after reset.
    always_comb
    begin
        busy_next    = busy_reg;
        clr_idx_next = clr_idx_reg;
        if (busy_reg)
        begin
            clr_idx_next = clr_idx_reg + AW'(1);
            if (clr_idx_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    // The sweep owns the write port while it runs.
    always_comb
    begin
        mem_we    = we;
        mem_waddr = waddr;
        mem_wdata = wdata;
        if (busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
    end

    // Memory array with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

    // The sweep ends only after the last entry has been cleared.
    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> ($past(clr_idx_reg) == LAST_IDX))
        else $error("clearing pass ended early");

    // No read is issued while the memory is still being cleared.
    a_no_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !re)
        else $error("read during clearing pass");

endmodule

// ===== hdl/earb_ctrl.sv =====
// ============================================================================
// earb_ctrl: pointer, counter and flag logic of the ring buffer
// Decodes each accepted word, updates the write and read pointers, does the
// distance check at block start and issues the memory accesses.
// ============================================================================
module earb_ctrl
    import earb_pkg::*;
#(
    parameter int CHUNK_SIZE        = CHUNK_SIZE_DEF,
    parameter int MAX_CHUNKS        = MAX_CHUNKS_DEF,
    parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF,
    localparam int DEPTH            = MAX_CHUNKS * CHUNK_SIZE,
    localparam int AW               = $clog2(DEPTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                accept,
    input  logic [OP_W-1:0]     opcode,
    input  logic [SAMPLE_W-1:0] sample_in,
    input  logic [POS_W-1:0]    frame_pos,
    input  logic                block_start,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [SAMPLE_W-1:0] mem_wdata,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    output logic                rd_load,
    output rd_info_t            rd_info
);

    localparam int LEN_W     = $clog2(DEPTH + 1);
    localparam int CMP_W     = 12;
    localparam int RST_CHUNK = (MAX_CHUNKS < RESET_CHUNKS) ? MAX_CHUNKS : RESET_CHUNKS;
    localparam int RST_LEN   = RST_CHUNK * CHUNK_SIZE;

    mode_t             mode_reg;
    mode_t             mode_next;
    logic              dev_reg;
    logic              dev_next;
    logic              ovr_reg;
    logic              ovr_next;
    logic              unr_pend_reg;
    logic              unr_pend_next;
    logic              unr_blk_reg;
    logic              unr_blk_next;
    logic [CNT_W-1:0]  wc_reg;
    logic [CNT_W-1:0]  wc_next;
    logic [CNT_W-1:0]  rc_reg;
    logic [CNT_W-1:0]  rc_next;
    logic [AW-1:0]     wa_reg;
    logic [AW-1:0]     wa_next;
    logic [AW-1:0]     ra_reg;
    logic [AW-1:0]     ra_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  half_reg;
    logic [LEN_W-1:0]  half_next;
    logic [LEN_W-1:0]  quart_reg;
    logic [LEN_W-1:0]  quart_next;
    logic [LEN_W-1:0]  tq_reg;
    logic [LEN_W-1:0]  tq_next;

    logic              is_write;
    logic              is_read;
    logic              started;
    logic              restart;
    logic              write_ok;
    logic [CNT_W-1:0]  wc_eff;
    logic [CNT_W-1:0]  rc_eff;
    logic [AW-1:0]     ra_eff;
    logic [CNT_W-1:0]  distance;
    logic              ovr_eff;
    logic              unr_pend_eff;
    logic              unr_blk_eff;
    logic [LEN_W-1:0]  cfg_len;
    logic [LEN_W+1:0]  cfg_len3;
    logic              cfg_ok;

    // Address after one step, wrapping at the ring end.
    function automatic logic [AW-1:0] advance(input logic [AW-1:0] addr,
                                              input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] inc;
        inc = LEN_W'(addr) + LEN_W'(1);
        return (inc >= len) ? '0 : AW'(inc);
    endfunction

    // Ring length register and the thresholds derived from it.
    always_comb
    begin
        cfg_len    = LEN_W'(cfg_wdata) * LEN_W'(CHUNK_SIZE);
        cfg_len3   = {2'b00, cfg_len} * (LEN_W + 2)'(3);
        cfg_ok     = (cfg_wdata != '0) && (CMP_W'(cfg_wdata) <= CMP_W'(MAX_CHUNKS));
        len_next   = len_reg;
        half_next  = half_reg;
        quart_next = quart_reg;
        tq_next    = tq_reg;
        if (cfg_we && cfg_ok)
        begin
            len_next   = cfg_len;
            half_next  = cfg_len >> 1;
            quart_next = cfg_len >> 2;
            tq_next    = LEN_W'(cfg_len3 >> 2);
        end
    end

    // Decode of the accepted word.
    always_comb
    begin
        is_write = accept && (opcode == OP_WRITE) && (mode_reg != MODE_UNDEFINED);
        is_read  = accept && (opcode == OP_READ) && (mode_reg != MODE_UNDEFINED);
        started  = is_read && block_start;
        restart  = started && (mode_reg == MODE_WILL_START);
        write_ok = is_write
                && (CMP_W'(frame_pos) < CMP_W'(MAX_FRAME_SAMPLES))
                && !(ovr_reg && (CMP_W'(frame_pos) >= CMP_W'(CHUNK_SIZE)));
    end

    // Block start: optional pointer restart, then the distance check.
    always_comb
    begin
        wc_eff       = restart ? '0 : wc_reg;
        rc_eff       = restart ? (CNT_W'(0) - CNT_W'(half_reg)) : rc_reg;
        ra_eff       = restart ? '0 : ra_reg;
        distance     = wc_eff - rc_eff;
        ovr_eff      = ovr_reg;
        unr_pend_eff = unr_pend_reg;
        unr_blk_eff  = unr_blk_reg;
        if (started)
        begin
            ovr_eff      = !distance[CNT_W-1] && (distance > CNT_W'(tq_reg));
            unr_pend_eff = distance[CNT_W-1] || (distance < CNT_W'(quart_reg));
            unr_blk_eff  = unr_pend_eff;
        end
    end

    // Run mode.
    always_comb
    begin
        mode_next = mode_reg;
        if (accept && (opcode == OP_RESTART))
        begin
            mode_next = MODE_WILL_START;
        end
        else if (restart && dev_reg)
        begin
            mode_next = MODE_RUNNING;
        end
    end

    // Pointer, counter and flag updates.
    always_comb
    begin
        dev_next      = dev_reg;
        ovr_next      = ovr_eff;
        unr_pend_next = unr_pend_eff;
        unr_blk_next  = unr_blk_eff;
        wc_next       = wc_eff;
        rc_next       = rc_eff;
        wa_next       = restart ? '0 : wa_reg;
        ra_next       = ra_eff;
        if (accept && (opcode == OP_CONNECT))
        begin
            dev_next = 1'b1;
        end
        if (accept && (opcode == OP_DISCONNECT))
        begin
            dev_next = 1'b0;
        end
        if (write_ok)
        begin
            wa_next = advance(wa_reg, len_reg);
            wc_next = wc_reg + CNT_W'(1);
        end
        if (is_read)
        begin
            if (unr_pend_eff)
            begin
                unr_pend_next = 1'b0;
            end
            else
            begin
                if (!rc_eff[CNT_W-1])
                begin
                    ra_next = advance(ra_eff, len_reg);
                end
                rc_next = rc_eff + CNT_W'(1);
            end
        end
    end

    // Memory requests and the record for the output stage.
    always_comb
    begin
        mem_we             = write_ok;
        mem_waddr          = wa_reg;
        mem_wdata          = sample_in;
        mem_re             = is_read && !rc_eff[CNT_W-1];
        mem_raddr          = ra_eff;
        rd_load            = is_read;
        rd_info.use_mem    = !rc_eff[CNT_W-1];
        rd_info.clear_held = block_start;
        rd_info.underrun   = unr_blk_eff;
        rd_info.overrun    = ovr_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_UNDEFINED;
            dev_reg      <= 1'b0;
            ovr_reg      <= 1'b0;
            unr_pend_reg <= 1'b0;
            unr_blk_reg  <= 1'b0;
            wc_reg       <= '0;
            rc_reg       <= '0;
            wa_reg       <= '0;
            ra_reg       <= '0;
            len_reg      <= LEN_W'(RST_LEN);
            half_reg     <= LEN_W'(RST_LEN / 2);
            quart_reg    <= LEN_W'(RST_LEN / 4);
            tq_reg       <= LEN_W'(RST_LEN * 3 / 4);
        end
        else
        begin
            mode_reg     <= mode_next;
            dev_reg      <= dev_next;
            ovr_reg      <= ovr_next;
            unr_pend_reg <= unr_pend_next;
            unr_blk_reg  <= unr_blk_next;
            wc_reg       <= wc_next;
            rc_reg       <= rc_next;
            wa_reg       <= wa_next;
            ra_reg       <= ra_next;
            len_reg      <= len_next;
            half_reg     <= half_next;
            quart_reg    <= quart_next;
            tq_reg       <= tq_next;
        end
    end

    // A restart at block start leaves the write counter at zero.
    a_restart_wc: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (wc_reg == '0))
        else $error("write counter not cleared on restart");

    // A read that is not a block start always consumes a pending underrun.
    a_unr_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (is_read && !block_start) |=> !unr_pend_reg)
        else $error("pending underrun survived a read");

endmodule

// ===== hdl/earb_out.sv =====
// ============================================================================
// earb_out: held sample and output register of the ring buffer
// Takes the registered memory data in stage one, resolves the held
// sample and passes the result word to the output register.
// ============================================================================
module earb_out
    import earb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_load,
    input  rd_info_t            rd_info,
    input  logic [SAMPLE_W-1:0] rd_data,
    input  logic                out_stall,
    output logic                hold,
    output logic                out_valid,
    output logic [SAMPLE_W-1:0] sample_out,
    output logic                underrun_active,
    output logic                overrun_active
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    rd_info_t            s1_info_reg;
    logic [SAMPLE_W-1:0] held_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic                out_unr_reg;
    logic                out_ovr_reg;
    logic                s1_advance;
    logic [SAMPLE_W-1:0] s1_sample;

    // Stage one moves on when the output register is empty or being taken.
    always_comb
    begin
        s1_advance = !out_valid_reg || !out_stall;
        hold       = s1_valid_reg && !s1_advance;
        if (s1_info_reg.use_mem)
        begin
            s1_sample = rd_data;
        end
        else if (s1_info_reg.clear_held)
        begin
            s1_sample = '0;
        end
        else
        begin
            s1_sample = held_reg;
        end
    end

    // Valid bits of stage one and of the output register.
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (rd_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_valid_reg && s1_advance)
            begin
                held_reg <= s1_sample;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rd_load)
        begin
            s1_info_reg <= rd_info;
        end
        if (s1_valid_reg && s1_advance)
        begin
            out_sample_reg <= s1_sample;
            out_unr_reg    <= s1_info_reg.underrun;
            out_ovr_reg    <= s1_info_reg.overrun;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sample_out      = out_sample_reg;
    assign underrun_active = out_unr_reg;
    assign overrun_active  = out_ovr_reg;

    // Stage one is never overwritten while it waits on the output.
    a_no_load_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hold |-> !rd_load)
        else $error("read word loaded into a stalled stage");

    // A result appears only after a word sat in stage one.
    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("output valid without a word in stage one");

endmodule

// ===== hdl/elastic_audio_ring_buffer_top.sv =====
// ============================================================================
// elastic_audio_ring_buffer_top: rate-matching audio ring buffer
// Stores 16-bit samples in a ring and plays them out, stretching or
// dropping samples to keep the write-to-read distance near half the ring.
// ============================================================================
// Usage:
// Input channel (in_valid / in_stall) carries one command word per cycle:
// write sample, read sample, restart, device connect or disconnect. A word
// is taken at a clock edge with in_valid high and in_stall low.
// Only read words after a restart produce a result word on the output
// channel (out_valid / out_stall); all other words produce nothing.
// Throughput is one word per cycle while in_stall stays low, limited by the
// single write port and single read port of the sample memory. The memory
// read of a read word is registered as the word is taken into stage one,
// and out_valid rises when the output register loads from stage one.
// The ring length is written through cfg_we / cfg_wdata while the block is
// idle; software issues a restart afterwards.
// After reset the sample memory is cleared to zero, one entry per cycle,
// over all MAX_CHUNKS * CHUNK_SIZE entries (512 by default); in_stall stays
// high during that pass. Configuration writes are taken at any time.
// When the receiver stalls, one more read word is taken into the read stage
// (other words still pass) and then in_stall rises until the output drains.
// ============================================================================
module elastic_audio_ring_buffer_top
    import earb_pkg::*;
#(
    parameter int CHUNK_SIZE        = CHUNK_SIZE_DEF,
    parameter int MAX_CHUNKS        = MAX_CHUNKS_DEF,
    parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OP_W-1:0]            opcode,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [POS_W-1:0]           frame_pos,
    input  logic                       block_start,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       underrun_active,
    output logic                       overrun_active
);

    localparam int DEPTH = MAX_CHUNKS * CHUNK_SIZE;
    localparam int AW    = $clog2(DEPTH);

    logic                accept;
    logic                hold;
    logic                busy;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [SAMPLE_W-1:0] mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [SAMPLE_W-1:0] rd_data;
    logic                rd_load;
    rd_info_t            rd_info;
    logic [SAMPLE_W-1:0] sample_out_u;

    // Input handshake.
    assign in_stall = hold || busy;
    assign accept   = in_valid && !in_stall;

    earb_ctrl #(
        .CHUNK_SIZE        (CHUNK_SIZE),
        .MAX_CHUNKS        (MAX_CHUNKS),
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .opcode      (opcode),
        .sample_in   (sample_in),
        .frame_pos   (frame_pos),
        .block_start (block_start),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .rd_load     (rd_load),
        .rd_info     (rd_info)
    );

    earb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .rd_data (rd_data),
        .busy    (busy)
    );

    earb_out u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .rd_load         (rd_load),
        .rd_info         (rd_info),
        .rd_data         (rd_data),
        .out_stall       (out_stall),
        .hold            (hold),
        .out_valid       (out_valid),
        .sample_out      (sample_out_u),
        .underrun_active (underrun_active),
        .overrun_active  (overrun_active)
    );

    assign sample_out = sample_out_u;

endmodule
